### rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define ASSERT_SAME(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Check that cons holds in the cycle after ante.
`define ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### rtl/rss_pkg.sv
// Shared constants, types and helpers for the substring replace stream.
`default_nettype none

package rss_pkg;

  localparam int NeedleMax = 8;
  localparam int ReplMax   = 8;
  localparam int BurstMax  = (NeedleMax > ReplMax) ? NeedleMax : ReplMax;

  localparam int ByteW     = 8;
  localparam int RegW      = 64;
  localparam int LenW      = 4;
  localparam int WinCntW   = $clog2(NeedleMax + 1);
  localparam int WinIdxW   = (NeedleMax > 1) ? $clog2(NeedleMax) : 1;
  localparam int ReplCntW  = $clog2(ReplMax + 1);
  localparam int CntW      = $clog2(BurstMax + 1);
  localparam int IdxW      = (BurstMax > 1) ? $clog2(BurstMax) : 1;

  typedef logic [ByteW-1:0] byte_t;

  typedef enum logic [1:0] {
    CfgNeedleBytes = 2'd0,
    CfgNeedleLen   = 2'd1,
    CfgReplBytes   = 2'd2,
    CfgReplLen     = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    byte_t [NeedleMax-1:0] needle;
    logic  [WinCntW-1:0]   needle_len;
    byte_t [ReplMax-1:0]   repl;
    logic  [ReplCntW-1:0]  repl_len;
  } cfg_t;

  typedef struct packed {
    byte_t [BurstMax-1:0] bytes;
    logic  [CntW-1:0]     count;
    logic                 has;
    logic                 last;
  } burst_t;

  function automatic logic [LenW-1:0] clamp_len(logic [LenW-1:0] len, logic [LenW-1:0] maxv);
    clamp_len = (len > maxv) ? maxv : len;
  endfunction

endpackage

`default_nettype wire

### rtl/rss_core.sv
// Match window and per-word burst composer.
`default_nettype none

module rss_core (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire rss_pkg::cfg_t   cfg_i,
  input  wire logic            clr_i,
  input  wire logic            load_i,
  input  wire rss_pkg::byte_t  in_byte_i,
  input  wire logic            in_last_i,
  output rss_pkg::burst_t      burst_o
);
  import rss_pkg::*;

  byte_t [NeedleMax-1:0] win_q, win_d, nw;
  logic  [WinCntW-1:0]   cnt_q, cnt_d, cur, ncnt;
  logic                  full, match;

  always_comb begin
    cur  = (cnt_q >= cfg_i.needle_len) ? '0 : cnt_q;
    nw   = win_q;
    nw[cur[WinIdxW-1:0]] = in_byte_i;
    ncnt = cur + WinCntW'(1);
    full = (ncnt == cfg_i.needle_len);
    match = 1'b1;
    for (int i = 0; i < NeedleMax; i++) begin
      if ((i < int'(cfg_i.needle_len)) && (nw[i] != cfg_i.needle[i])) begin
        match = 1'b0;
      end
    end
  end

  always_comb begin
    burst_o = '0;
    for (int i = 0; i < BurstMax; i++) begin
      if (i < NeedleMax) begin
        burst_o.bytes[i] = nw[i];
      end
    end
    burst_o.has  = 1'b1;
    burst_o.last = 1'b0;
    win_d = win_q;
    cnt_d = cnt_q;
    if (cfg_i.needle_len == '0) begin
      burst_o.bytes[0] = in_byte_i;
      burst_o.count    = CntW'(1);
      burst_o.last     = in_last_i;
    end else begin
      if (full && match) begin
        for (int i = 0; i < BurstMax; i++) begin
          if (i < ReplMax) begin
            burst_o.bytes[i] = cfg_i.repl[i];
          end else begin
            burst_o.bytes[i] = '0;
          end
        end
        burst_o.count = CntW'(cfg_i.repl_len);
        cnt_d = '0;
      end else if (full) begin
        burst_o.count = CntW'(1);
        for (int i = 0; i < NeedleMax - 1; i++) begin
          win_d[i] = nw[i+1];
        end
        cnt_d = cfg_i.needle_len - WinCntW'(1);
      end else begin
        win_d = nw;
        cnt_d = ncnt;
      end
      if (in_last_i) begin
        if (!(full && match)) begin
          burst_o.count = CntW'(ncnt);
        end
        cnt_d = '0;
        burst_o.last = 1'b1;
        if (burst_o.count == '0) begin
          burst_o.bytes[0] = '0;
          burst_o.has      = 1'b0;
          burst_o.count    = CntW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (clr_i) begin
      cnt_q <= '0;
    end else if (load_i) begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      win_q <= win_d;
    end
  end

endmodule

`default_nettype wire

### rtl/rss_burst.sv
// Output register that plays a burst out one word per cycle while out_ready_i is high.
`default_nettype none

module rss_burst (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire rss_pkg::burst_t   burst_i,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output rss_pkg::byte_t         out_data_o,
  output logic                   out_user_o,
  output logic                   out_last_o
);
  import rss_pkg::*;

  byte_t [BurstMax-1:0] bytes_q;
  logic  [CntW-1:0]     cnt_q;
  logic  [IdxW-1:0]     idx_q;
  logic                 has_q, last_q;
  logic                 busy, final_beat, drain, load;

  assign busy       = (cnt_q != '0);
  assign final_beat = (CntW'(idx_q) == (cnt_q - CntW'(1)));
  assign drain      = busy && out_ready_i && final_beat;
  assign in_ready_o = !busy || drain;
  assign load       = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      idx_q <= '0;
    end else if (load) begin
      cnt_q <= burst_i.count;
      idx_q <= '0;
    end else if (busy && out_ready_i) begin
      if (final_beat) begin
        cnt_q <= '0;
      end else begin
        idx_q <= idx_q + IdxW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      bytes_q <= burst_i.bytes;
      has_q   <= burst_i.has;
      last_q  <= burst_i.last;
    end
  end

  assign out_valid_o = busy;
  assign out_data_o  = bytes_q[idx_q];
  assign out_user_o  = has_q;
  assign out_last_o  = last_q && final_beat;

endmodule

`default_nettype wire

### rtl/substring_replace_stream.sv
// Top level of the substring replace stream: config registers and datapath.
//
// Input words arrive on the s_axis channel, one text byte each, tlast on the
// final byte. Output words leave on the m_axis channel: tdata is the byte,
// tuser is 1 when the byte is valid and 0 for a bare end marker, tlast marks
// the final word of the text.
// Every occurrence of the needle (leftmost, non-overlapping) is replaced.
// An accepted word is turned into a burst of 0 to 8 output words in the same
// cycle; the first one shows on m_axis in the next cycle.
// Throughput is one input word per cycle while each word yields at most one
// output word and m_axis_tready_i is high; a burst of k words holds the
// output register until all k words are taken, which sets the input rate.
// s_axis_tready_o rises in the cycle a burst's last word is taken (no gaps).
// When the receiver stalls, the current word holds and s_axis_tready_o falls.
// Reset clears config registers (pass-through), the window and the burst.
// Config is written through cfg_we_i/cfg_idx_i/cfg_wdata_i while idle;
// writing the needle length empties the window.
`default_nettype none

module substring_replace_stream (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire rss_pkg::cfg_idx_e  cfg_idx_i,
  input  wire logic [63:0]        cfg_wdata_i,
  input  wire logic               s_axis_tvalid_i,
  output logic                    s_axis_tready_o,
  input  wire logic [7:0]         s_axis_tdata_i,   // [7:0] in_byte
  input  wire logic               s_axis_tlast_i,
  output logic                    m_axis_tvalid_o,
  input  wire logic               m_axis_tready_i,
  output logic [7:0]              m_axis_tdata_o,   // [7:0] out_byte
  output logic                    m_axis_tuser_o,   // [0] out_has_byte
  output logic                    m_axis_tlast_o
);
  import rss_pkg::*;

  logic [NeedleMax*ByteW-1:0] needle_q;
  logic [ReplMax*ByteW-1:0]   repl_q;
  logic [LenW-1:0]            nlen_q, rlen_q;
  cfg_t                       cfg;
  burst_t                     burst;
  logic                       clr, accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      needle_q <= '0;
      nlen_q   <= '0;
      repl_q   <= '0;
      rlen_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgNeedleBytes: needle_q <= cfg_wdata_i[NeedleMax*ByteW-1:0];
        CfgNeedleLen:   nlen_q   <= cfg_wdata_i[LenW-1:0];
        CfgReplBytes:   repl_q   <= cfg_wdata_i[ReplMax*ByteW-1:0];
        CfgReplLen:     rlen_q   <= cfg_wdata_i[LenW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.needle     = needle_q;
    cfg.repl       = repl_q;
    cfg.needle_len = WinCntW'(clamp_len(nlen_q, LenW'(NeedleMax)));
    cfg.repl_len   = ReplCntW'(clamp_len(rlen_q, LenW'(ReplMax)));
  end

  assign clr    = cfg_we_i && (cfg_idx_i == CfgNeedleLen);
  assign accept = s_axis_tvalid_i && s_axis_tready_o;

  rss_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .clr_i     (clr),
    .load_i    (accept),
    .in_byte_i (s_axis_tdata_i),
    .in_last_i (s_axis_tlast_i),
    .burst_o   (burst)
  );

  rss_burst u_burst (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .burst_i     (burst),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (m_axis_tdata_o),
    .out_user_o  (m_axis_tuser_o),
    .out_last_o  (m_axis_tlast_o)
  );

endmodule

`default_nettype wire

### rtl/rss_checker.sv
// Port-level assertions for the substring replace stream, bound to the top.
`default_nettype none
`include "assert_macros.svh"

module rss_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               s_axis_tready_o,
  input wire logic               m_axis_tvalid_o,
  input wire logic               m_axis_tready_i,
  input wire logic [7:0]         m_axis_tdata_o,
  input wire logic               m_axis_tuser_o,
  input wire logic               m_axis_tlast_o
);

  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tready_i, m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o))
  `ASSERT_SAME(a_idle_ready, clk_i, rst_ni, !m_axis_tvalid_o, s_axis_tready_o)
  `ASSERT_SAME(a_marker_last, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tuser_o, m_axis_tlast_o)
  `ASSERT_SAME(a_marker_zero, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tuser_o, m_axis_tdata_o == 8'd0)

endmodule

bind substring_replace_stream rss_checker u_rss_checker (.*);

`default_nettype wire

### tb/tb_top.sv
// Self-checking testbench for the substring replace stream: directed table, then random texts.
`timescale 1ns / 1ps

module tb_top;
  import rss_pkg::*;

  localparam int WatchdogLimit = 4000;
  localparam int SettleCycles  = 4;
  localparam int DrainCycles   = 16;
  localparam int SegItems      = 45;
  localparam int Segments      = 8;
  localparam int PlanLen       = 38;

  typedef struct packed {
    byte_t data;
    logic  has_byte;
    logic  last;
  } out_word_t;

  typedef enum logic {RowWord, RowCfg} row_kind_e;

  typedef struct packed {
    row_kind_e   kind;
    cfg_idx_e    idx;
    logic [63:0] value;
    logic        last;
    logic        typed;
    out_word_t   want;
  } row_t;

  localparam row_t Plan [PlanLen] = '{
    '{RowWord, CfgNeedleBytes, 64'h00, 1'b0, 1'b1, '{8'h00, 1'b1, 1'b0}},
    '{RowWord, CfgNeedleBytes, 64'hFF, 1'b1, 1'b1, '{8'hFF, 1'b1, 1'b1}},
    '{RowCfg,  CfgNeedleBytes, 64'h6261, 1'b0, 1'b0, '0},
    '{RowCfg,  CfgNeedleLen,   64'd2, 1'b0, 1'b0, '0},
    '{RowCfg,  CfgReplBytes,   64'h5A5958, 1'b0, 1'b0, '0},
    '{RowCfg,  CfgReplLen,     64'd3, 1'b0, 1'b0, '0},
    '{RowWord, CfgNeedleBytes, 64'h78, 1'b0, 1'b0, '0},
    '{RowWord, CfgNeedleBytes, 64'h61, 1'b0, 1'b0, '0},
    '{RowWord, CfgNeedleBytes, 64'h62, 1'b0, 1'b0, '0},
    '{RowWord, CfgNeedleBytes, 64'h61, 1'b0, 1'b0, '0},
    '{RowWord, CfgNeedleBytes, 64'h61, 1'b0, 1'b0, '0},
    '{RowWord, CfgNeedleBytes, 64'h62, 1'b0, 1'b0, '0},
    '{RowWord, CfgNeedleBytes, 64'h63, 1'b1, 1'b0, '0},
    '{RowCfg,  CfgReplLen,     64'd0, 1'b0, 1'b0, '0},
    '{RowWord, CfgNeedleBytes, 64'h61, 1'b0, 1'b0, '0},
    '{RowWord, CfgNeedleBytes, 64'h62, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1}},
    '{RowCfg,  CfgNeedleBytes, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0, '0},
    '{RowCfg,  CfgNeedleLen,   64'd15, 1'b0, 1'b0, '0},
    '{RowCfg,  CfgReplBytes,   64'h0011_2233_4455_6677, 1'b0, 1'b0, '0},
    '{RowCfg,  CfgReplLen,     64'd15, 1'b0, 1'b0, '0},
    '{RowWord, CfgNeedleBytes, 64'hFF, 1'b0, 1'b0, '0},
    '{RowWord, CfgNeedleBytes, 64'hFF, 1'b0, 1'b0, '0},
    '{RowWord, CfgNeedleBytes, 64'hFF, 1'b0, 1'b0, '0},
    '{RowWord, CfgNeedleBytes, 64'hFF, 1'b0, 1'b0, '0},
    '{RowWord, CfgNeedleBytes, 64'hFF, 1'b0, 1'b0, '0},
    '{RowWord, CfgNeedleBytes, 64'hFF, 1'b0, 1'b0, '0},
    '{RowWord, CfgNeedleBytes, 64'hFF, 1'b0, 1'b0, '0},
    '{RowWord, CfgNeedleBytes, 64'hFF, 1'b1, 1'b0, '0},
    '{RowWord, CfgNeedleBytes, 64'h00, 1'b1, 1'b0, '0},
    '{RowCfg,  CfgNeedleBytes, 64'h6261, 1'b0, 1'b0, '0},
    '{RowCfg,  CfgNeedleLen,   64'd2, 1'b0, 1'b0, '0},
    '{RowCfg,  CfgReplBytes,   64'h51, 1'b0, 1'b0, '0},
    '{RowCfg,  CfgReplLen,     64'd1, 1'b0, 1'b0, '0},
    '{RowWord, CfgNeedleBytes, 64'h61, 1'b0, 1'b0, '0},
    '{RowCfg,  CfgNeedleLen,   64'd2, 1'b0, 1'b0, '0},
    '{RowWord, CfgNeedleBytes, 64'h62, 1'b1, 1'b1, '{8'h62, 1'b1, 1'b1}},
    '{RowCfg,  CfgNeedleLen,   64'd1, 1'b0, 1'b0, '0},
    '{RowWord, CfgNeedleBytes, 64'h61, 1'b1, 1'b1, '{8'h51, 1'b1, 1'b1}}
  };

  logic        clk_i;
  logic        rst_n     = 1'b0;
  logic        cfg_we    = 1'b0;
  cfg_idx_e    cfg_idx   = CfgNeedleBytes;
  logic [63:0] cfg_wdata = '0;
  logic        s_tvalid  = 1'b0;
  byte_t       s_tdata   = '0;
  logic        s_tlast   = 1'b0;
  logic        m_tready  = 1'b0;

  logic        s_axis_tready_o;
  logic        m_axis_tvalid_o;
  logic [7:0]  m_axis_tdata_o;
  logic        m_axis_tuser_o;
  logic        m_axis_tlast_o;

  int src_idle   = 0;
  int sink_stall = 0;
  int errors     = 0;
  int quiet      = 0;

  logic [63:0] pred_needle;
  logic [3:0]  pred_needle_len;
  logic [63:0] pred_repl;
  logic [3:0]  pred_repl_len;
  byte_t       pred_win [NeedleMax];
  int          pred_win_cnt;

  out_word_t   expected_words [$];
  out_word_t   burst_words [$];

  substring_replace_stream dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tlast_i  (s_tlast),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic int eff_needle_len();
    return (pred_needle_len > NeedleMax) ? NeedleMax : int'(pred_needle_len);
  endfunction

  function automatic out_word_t mk_word(byte_t b, logic has_byte, logic last);
    out_word_t w;
    w.data     = b;
    w.has_byte = has_byte;
    w.last     = last;
    return w;
  endfunction

  // Fill burst_words with what one text byte produces and advance the window.
  function automatic void rewrite_byte(byte_t b, logic last);
    int  nl;
    int  rl;
    int  i;
    bit  hit;
    burst_words.delete();
    nl = eff_needle_len();
    rl = (pred_repl_len > ReplMax) ? ReplMax : int'(pred_repl_len);
    if (nl == 0) begin
      burst_words.push_back(mk_word(b, 1'b1, last));
      return;
    end
    if (pred_win_cnt >= nl) pred_win_cnt = 0;
    pred_win[pred_win_cnt] = b;
    pred_win_cnt++;
    if (pred_win_cnt >= nl) begin
      hit = 1'b1;
      for (i = 0; i < nl; i++)
        if (pred_win[i] != pred_needle[8*i +: 8]) hit = 1'b0;
      if (hit) begin
        for (i = 0; i < rl; i++) burst_words.push_back(mk_word(pred_repl[8*i +: 8], 1'b1, 1'b0));
        pred_win_cnt = 0;
      end else begin
        burst_words.push_back(mk_word(pred_win[0], 1'b1, 1'b0));
        for (i = 1; i < pred_win_cnt; i++) pred_win[i-1] = pred_win[i];
        pred_win_cnt--;
      end
    end
    if (last) begin
      for (i = 0; i < pred_win_cnt; i++) burst_words.push_back(mk_word(pred_win[i], 1'b1, 1'b0));
      pred_win_cnt = 0;
      if (burst_words.size() == 0) burst_words.push_back(mk_word(8'h00, 1'b0, 1'b1));
      else burst_words[burst_words.size()-1].last = 1'b1;
    end
  endfunction

  task automatic settle(int cycles);
    s_tvalid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (cycles) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [63:0] value);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= value;
    @(posedge clk_i);
    case (idx)
      CfgNeedleBytes: pred_needle = value;
      CfgNeedleLen: begin
        pred_needle_len = value[3:0];
        pred_win_cnt    = 0;
      end
      CfgReplBytes: pred_repl = value;
      CfgReplLen:   pred_repl_len = value[3:0];
      default: ;
    endcase
    cfg_we <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_word(byte_t b, logic last, logic typed, out_word_t want);
    while ($urandom_range(99) < src_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready_o);
    rewrite_byte(b, last);
    if (typed) expected_words.push_back(want);
    else foreach (burst_words[k]) expected_words.push_back(burst_words[k]);
  endtask

  always @(posedge clk_i) begin
    m_tready <= ($urandom_range(99) >= sink_stall);
  end

  always @(posedge clk_i) begin
    out_word_t w;
    if (rst_n && m_axis_tvalid_o && m_tready) begin
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual %h/%b/%b", $time,
                 m_axis_tdata_o, m_axis_tuser_o, m_axis_tlast_o);
        errors++;
      end else begin
        w = expected_words.pop_front();
        if (w.data != m_axis_tdata_o || w.has_byte != m_axis_tuser_o ||
            w.last != m_axis_tlast_o) begin
          $display("%0t: word mismatch, expected %h/%b/%b, actual %h/%b/%b", $time,
                   w.data, w.has_byte, w.last, m_axis_tdata_o, m_axis_tuser_o,
                   m_axis_tlast_o);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_n) begin
      if ((s_tvalid && s_axis_tready_o) || (m_axis_tvalid_o && m_tready)) quiet = 0;
      else quiet++;
      if (quiet >= WatchdogLimit) begin
        $display("%0t: no word moved for %0d cycles", $time, WatchdogLimit);
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  initial begin
    int          seg;
    int          sent;
    int          n;
    int          i;
    int          k;
    int          frag;
    int          pick;
    int          nl;
    byte_t       b;
    bit          narrow;
    logic [63:0] needle;
    int          nlen_tab [Segments];
    int          rlen_tab [Segments];

    nlen_tab = '{2, 1, 8, 3, 0, 15, 4, 6};
    rlen_tab = '{3, 0, 8, 15, 1, 5, 2, 9};

    pred_needle     = '0;
    pred_needle_len = '0;
    pred_repl       = '0;
    pred_repl_len   = '0;
    pred_win_cnt    = 0;

    repeat (5) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    for (i = 0; i < PlanLen; i++) begin
      if (Plan[i].kind == RowCfg) begin
        settle(SettleCycles);
        write_reg(Plan[i].idx, Plan[i].value);
      end else begin
        send_word(Plan[i].value[7:0], Plan[i].last, Plan[i].typed, Plan[i].want);
      end
    end

    for (seg = 0; seg < Segments; seg++) begin
      settle(SettleCycles);
      case (seg % 4)
        0: begin src_idle = 0;  sink_stall = 0;  end
        1: begin src_idle = 61; sink_stall = 0;  end
        2: begin src_idle = 0;  sink_stall = 61; end
        default: begin src_idle = 21; sink_stall = 21; end
      endcase
      narrow = $urandom_range(1);
      needle = {$urandom, $urandom};
      if (narrow)
        for (k = 0; k < NeedleMax; k++) needle[8*k +: 8] = 8'h41 + 8'($urandom_range(1));
      write_reg(CfgNeedleBytes, needle);
      write_reg(CfgNeedleLen, 64'(nlen_tab[seg]));
      write_reg(CfgReplBytes, {$urandom, $urandom});
      write_reg(CfgReplLen, 64'(rlen_tab[seg]));
      nl   = eff_needle_len();
      sent = 0;
      while (sent < SegItems) begin
        n = $urandom_range(12, 1);
        i = 0;
        while (i < n) begin
          pick = $urandom_range(9);
          if (nl == 0 || pick >= 7) begin
            if ($urandom_range(1) || nl == 0) b = 8'($urandom_range(255));
            else b = pred_needle[8*$urandom_range(nl-1) +: 8];
            send_word(b, i == n - 1, 1'b0, '0);
            i++;
          end else begin
            frag = (pick < 5) ? nl : $urandom_range(nl, 1);
            for (k = 0; k < frag && i < n; k++) begin
              send_word(pred_needle[8*k +: 8], i == n - 1, 1'b0, '0);
              i++;
            end
          end
        end
        sent += n;
      end
    end

    settle(DrainCycles);
    if (errors == 0 && expected_words.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl
rtl/rss_pkg.sv
rtl/rss_core.sv
rtl/rss_burst.sv
rtl/substring_replace_stream.sv
rtl/rss_checker.sv
tb/tb_top.sv
